// ===== rtl/snxh_pkg.sv =====
// ----------------------------------------------------------------------------
// snxh_pkg
// Shared constants and controller command type for the symbol name hash.
// ----------------------------------------------------------------------------
package snxh_pkg;

	localparam int BYTE_W     = 8;
	localparam int SUM_W      = 32;
	localparam int PART_W     = 24;
	localparam int BKT_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int ROT_BITS   = 4;
	localparam int DIV_STEPS  = SUM_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [BYTE_W-1:0] CASE_MASK = 8'hDF;
	localparam logic [1:0]        POS_LAST  = 2'd3;

	typedef enum logic {
		REG_ROTATE_MODE  = 1'b0,
		REG_BUCKET_COUNT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic accept;
		logic last;
		logic div_step;
		logic load_out;
	} ctrl_cmd_t;

endpackage

// ===== rtl/snxh_datapath.sv =====
// ----------------------------------------------------------------------------
// snxh_datapath
// Byte folding, XOR/rotate sum, restoring remainder unit and result register.
// ----------------------------------------------------------------------------
module snxh_datapath import snxh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	input  logic [BYTE_W-1:0]     name_byte,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [SUM_W-1:0]      checksum,
	output logic [BKT_W-1:0]      bucket,
	output logic                  zero_divisor
);

	logic              rotate_q;
	logic [BKT_W-1:0]  bucket_count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PART_W-1:0] partial_q;
	logic [1:0]        pos_q;
	logic [SUM_W-1:0]  cks_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [BKT_W-1:0]  div_q;
	logic [BKT_W-1:0]  rem_q;
	logic              zero_q;
	logic [SUM_W-1:0]  checksum_q;
	logic [BKT_W-1:0]  bucket_q;
	logic              zero_divisor_q;

	logic [BYTE_W-1:0] b;
	logic [SUM_W-1:0]  word_x;
	logic [SUM_W-1:0]  grp_sum;
	logic [PART_W-1:0] partial_nx;
	logic [SUM_W-1:0]  final_sum;
	logic [BKT_W:0]    rr;
	logic [BKT_W:0]    diff;
	logic [BKT_W-1:0]  rem_nx;

	always_comb begin
		b       = name_byte & CASE_MASK;
		word_x  = sum_q ^ {b, partial_q};
		grp_sum = rotate_q ? ((word_x << ROT_BITS) | (word_x >> (SUM_W - ROT_BITS))) : word_x;
		unique case (pos_q)
			2'd0:    partial_nx = {16'h0000, b};
			2'd1:    partial_nx = {8'h00, b, partial_q[7:0]};
			2'd2:    partial_nx = {b, partial_q[15:0]};
			default: partial_nx = partial_q;
		endcase
		final_sum = (pos_q == POS_LAST) ? grp_sum : (sum_q ^ {partial_nx, 8'h00});
		rr        = {rem_q, dvd_q[SUM_W-1]};
		diff      = rr - {1'b0, div_q};
		rem_nx    = diff[BKT_W] ? rr[BKT_W-1:0] : diff[BKT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_q       <= 1'b1;
			bucket_count_q <= 16'd1;
			sum_q          <= '0;
			partial_q      <= '0;
			pos_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROTATE_MODE:  rotate_q       <= cfg_data[0];
					REG_BUCKET_COUNT: bucket_count_q <= cfg_data;
				endcase
			end
			if (cmd.accept) begin
				if (cmd.last) begin
					sum_q     <= '0;
					partial_q <= '0;
					pos_q     <= '0;
				end else if (pos_q == POS_LAST) begin
					sum_q     <= grp_sum;
					partial_q <= '0;
					pos_q     <= '0;
				end else begin
					partial_q <= partial_nx;
					pos_q     <= pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && cmd.last) begin
			cks_q  <= final_sum;
			dvd_q  <= final_sum;
			div_q  <= bucket_count_q;
			zero_q <= (bucket_count_q == '0);
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
		end
		if (cmd.load_out) begin
			checksum_q     <= cks_q;
			bucket_q       <= zero_q ? '0 : rem_q;
			zero_divisor_q <= zero_q;
		end
	end

	assign checksum     = checksum_q;
	assign bucket       = bucket_q;
	assign zero_divisor = zero_divisor_q;

endmodule

// ===== rtl/snxh_ctrl.sv =====
// ----------------------------------------------------------------------------
// snxh_ctrl
// Sequencer: byte intake, remainder step count and output register handshake.
// ----------------------------------------------------------------------------
module snxh_ctrl import snxh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tlast,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;

	always_comb begin
		s_tready     = (state_q == ST_RUN);
		cmd.accept   = s_tvalid && s_tready;
		cmd.last     = s_tlast;
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (cmd.accept && s_tlast) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// ===== rtl/symbol_name_xor_hash.sv =====
// The result is valid once the remainder unit has run and the output
// register is loaded. Throughput: one name byte per cycle; each name end
// stalls the input while the 32-step restoring remainder unit runs one bit
// per cycle, and longer while the previous result still waits in the output
// register. A waiting result does not block the bytes of the next name.
// Reset: arst_n clears the sum, byte count and handshake state at once;
// rotate_mode and bucket_count return to 1.
// ----------------------------------------------------------------------------
// symbol_name_xor_hash
// Case-folding XOR/rotate hash of a symbol name with bucket index.
// ----------------------------------------------------------------------------
module symbol_name_xor_hash import snxh_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,   // [7:0] name_byte
	input  logic                     s_tlast,   // last_byte
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [SUM_W+BKT_W-1:0]   m_tdata,   // [31:0] checksum, [47:32] bucket
	output logic                     m_tuser,   // zero_divisor
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	ctrl_cmd_t        cmd;
	logic [SUM_W-1:0] checksum;
	logic [BKT_W-1:0] bucket;

	snxh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	snxh_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.name_byte    (s_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_reg_t'(cfg_index)),
		.cfg_data     (cfg_data),
		.checksum     (checksum),
		.bucket       (bucket),
		.zero_divisor (m_tuser)
	);

	assign m_tdata = {bucket, checksum};

endmodule

// ===== rtl/snxh_checker.sv =====
// ----------------------------------------------------------------------------
// snxh_checker
// Port-level checks on the hash block, bound to the top level.
// ----------------------------------------------------------------------------
module snxh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input not stalled after last byte");

	a_zero_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[47:32] == 16'h0000)
		else $error("bucket not zero with zero divisor");

	a_result_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while input was open");

endmodule

bind symbol_name_xor_hash snxh_checker u_snxh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
